// ===== hdl/ffsa_pkg.sv =====
// Shared types and constants for the first-fit segment allocator.
package ffsa_pkg;

    localparam int ID_W     = 16;
    localparam int OWNER_W  = 17;
    localparam int START_W  = 20;
    localparam int LEN_W    = 21;
    localparam int STATUS_W = 3;

    localparam int MEMORY_BYTES_DEF = 1048576;
    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int MAX_SKIPPED_DEF  = 32;

    // owner bit 16 set marks a free segment
    localparam logic [OWNER_W-1:0] FREE_OWNER = 17'h10000;

    typedef enum logic [STATUS_W-1:0] {
        ST_PLACED  = 3'd0,
        ST_NOFIT   = 3'd1,
        ST_FREED   = 3'd2,
        ST_SKIPPED = 3'd3,
        ST_UNKNOWN = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_SETOWN = 2'd1,
        OP_SPLIT  = 2'd2,
        OP_MERGE  = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
    } seg_t;

    typedef struct packed {
        cell_op_t           op;
        logic               find_free;
        logic [ID_W-1:0]    id;
        logic [LEN_W-1:0]   size;
        logic [OWNER_W-1:0] owner;
    } cell_cmd_t;

    typedef struct packed {
        logic is_free;
        logic hit;
        logic exact;
    } cell_stat_t;

endpackage

// ===== hdl/first_fit_segment_allocator_core.sv =====
// Top level of the first-fit segment allocator: controller, cell row and skipped-ID store.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | in_valid, in_stall, kind, process_id,     | in
//          | request_size                              |
//  result  | out_valid, out_stall, status              | out
//
// One request at a time. A free first reads the skipped list, one entry at a time through S_SKRD and S_SKCMP.
// The segment scan moves a token one cell per cycle until a hit or the end of the segment count.
// A split, relabel or merge is a single command to the cell row; a free adds the merge states S_MNEXT and S_MPREV.
// Reset restores one free segment over the whole memory and an empty skipped list.
// The result sits in an output register; while it is stalled one more request runs,
// then waits in S_FINISH with the input stalled.
module first_fit_segment_allocator_core #(
    parameter int MEMORY_BYTES = ffsa_pkg::MEMORY_BYTES_DEF,
    parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
    parameter int MAX_SKIPPED  = ffsa_pkg::MAX_SKIPPED_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [ffsa_pkg::ID_W-1:0]     process_id,
    input  logic [ffsa_pkg::LEN_W-1:0]    request_size,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ffsa_pkg::STATUS_W-1:0] status
);

    localparam int CW  = $clog2(MAX_SEGMENTS + 1);
    localparam int IW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int SCW = $clog2(MAX_SKIPPED + 1);
    localparam int SAW = (MAX_SKIPPED > 1) ? $clog2(MAX_SKIPPED) : 1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SKRD   = 7'b0000010,
        S_SKCMP  = 7'b0000100,
        S_SCAN   = 7'b0001000,
        S_MNEXT  = 7'b0010000,
        S_MPREV  = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    state_t                       state_reg, state_next;
    logic                         kind_reg, kind_next;
    logic [ffsa_pkg::ID_W-1:0]    id_reg, id_next;
    logic [ffsa_pkg::LEN_W-1:0]   size_reg, size_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                j_reg, j_next;
    logic [CW-1:0]                pos_reg, pos_next;
    logic [SCW-1:0]               skcnt_reg, skcnt_next;
    logic [SCW-1:0]               skidx_reg, skidx_next;
    ffsa_pkg::status_t            res_reg, res_next;
    logic                         out_valid_reg, out_valid_next;
    ffsa_pkg::status_t            status_reg, status_next;

    ffsa_pkg::cell_cmd_t          cmd;
    logic [CW-1:0]                pos_sel;
    logic                         start;
    logic                         advance;
    logic                         note_skip;
    logic [CW-1:0]                nxt_pos;
    logic [CW-1:0]                prv_pos;

    ffsa_pkg::seg_t               segs [MAX_SEGMENTS];
    ffsa_pkg::cell_stat_t         stats [MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0]      toks;
    logic [MAX_SEGMENTS-1:0]      at_vec;
    logic [MAX_SEGMENTS-1:0]      past_vec;
    logic [MAX_SEGMENTS-1:0]      free_vec;
    logic [MAX_SEGMENTS-1:0]      hit_vec;
    logic [MAX_SEGMENTS-1:0]      exact_vec;
    logic                         hit_any;
    logic                         exact_any;

    logic [ffsa_pkg::ID_W-1:0]    sk_rdata;
    logic                         accept;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    // cell row
    for (genvar k = 0; k < MAX_SEGMENTS; k++)
    begin : g_cell
        ffsa_pkg::seg_t left_seg;
        ffsa_pkg::seg_t right_seg;
        logic           left_at;
        logic           tok_in;

        assign at_vec[k]   = (pos_sel == CW'(k));
        assign past_vec[k] = (CW'(k) > pos_sel);

        if (k == 0)
        begin : g_first
            assign left_seg = '0;
            assign left_at  = 1'b0;
            assign tok_in   = start;
        end
        else
        begin : g_rest
            assign left_seg = segs[k-1];
            assign left_at  = at_vec[k-1];
            assign tok_in   = toks[k-1] & advance;
        end

        if (k == MAX_SEGMENTS - 1)
        begin : g_last
            assign right_seg = '0;
        end
        else
        begin : g_mid
            assign right_seg = segs[k+1];
        end

        ffsa_cell #(
            .FIRST        (k == 0),
            .MEMORY_BYTES (MEMORY_BYTES)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .at_pos    (at_vec[k]),
            .past_pos  (past_vec[k]),
            .left_at   (left_at),
            .left_seg  (left_seg),
            .right_seg (right_seg),
            .tok_in    (tok_in),
            .seg       (segs[k]),
            .tok       (toks[k]),
            .stat      (stats[k])
        );

        assign free_vec[k]  = stats[k].is_free;
        assign hit_vec[k]   = stats[k].hit;
        assign exact_vec[k] = stats[k].exact;
    end

    assign hit_any   = |hit_vec;
    assign exact_any = |exact_vec;

    ffsa_ram #(
        .WIDTH (ffsa_pkg::ID_W),
        .DEPTH (MAX_SKIPPED)
    ) u_skipped (
        .clk   (clk),
        .we    (note_skip && (skcnt_reg < SCW'(MAX_SKIPPED))),
        .waddr (skcnt_reg[SAW-1:0]),
        .wdata (id_reg),
        .raddr (skidx_reg[SAW-1:0]),
        .rdata (sk_rdata)
    );

    assign nxt_pos = pos_reg + CW'(1);
    assign prv_pos = pos_reg - CW'(1);

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        id_next        = id_reg;
        size_next      = size_reg;
        count_next     = count_reg;
        j_next         = j_reg;
        pos_next       = pos_reg;
        skcnt_next     = skcnt_reg;
        skidx_next     = skidx_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;

        cmd.op        = ffsa_pkg::OP_HOLD;
        cmd.find_free = !kind_reg;
        cmd.id        = id_reg;
        cmd.size      = size_reg;
        cmd.owner     = {1'b0, id_reg};
        pos_sel       = pos_reg;
        start         = 1'b0;
        advance       = 1'b0;
        note_skip     = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = kind;
                    id_next    = process_id;
                    size_next  = request_size;
                    skidx_next = '0;
                    j_next     = '0;
                    if (kind && (skcnt_reg != '0))
                    begin
                        state_next = S_SKRD;
                    end
                    else
                    begin
                        start      = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SKRD:
            begin
                state_next = S_SKCMP;
            end
            S_SKCMP:
            begin
                if (sk_rdata == id_reg)
                begin
                    res_next   = ffsa_pkg::ST_SKIPPED;
                    state_next = S_FINISH;
                end
                else if (skidx_reg + SCW'(1) == skcnt_reg)
                begin
                    start      = 1'b1;
                    state_next = S_SCAN;
                end
                else
                begin
                    skidx_next = skidx_reg + SCW'(1);
                    state_next = S_SKRD;
                end
            end
            S_SCAN:
            begin
                pos_sel = j_reg;
                if (j_reg == count_reg)
                begin
                    if (!kind_reg)
                    begin
                        note_skip = 1'b1;
                        res_next  = ffsa_pkg::ST_NOFIT;
                    end
                    else
                    begin
                        res_next = ffsa_pkg::ST_UNKNOWN;
                    end
                    state_next = S_FINISH;
                end
                else if (hit_any)
                begin
                    pos_next = j_reg;
                    if (kind_reg)
                    begin
                        cmd.op     = ffsa_pkg::OP_SETOWN;
                        cmd.owner  = ffsa_pkg::FREE_OWNER;
                        state_next = S_MNEXT;
                    end
                    else if (exact_any)
                    begin
                        cmd.op     = ffsa_pkg::OP_SETOWN;
                        res_next   = ffsa_pkg::ST_PLACED;
                        state_next = S_FINISH;
                    end
                    else if (count_reg == CW'(MAX_SEGMENTS))
                    begin
                        note_skip  = 1'b1;
                        res_next   = ffsa_pkg::ST_FULL;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.op     = ffsa_pkg::OP_SPLIT;
                        count_next = count_reg + CW'(1);
                        res_next   = ffsa_pkg::ST_PLACED;
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    advance = 1'b1;
                    j_next  = j_reg + CW'(1);
                end
            end
            S_MNEXT:
            begin
                if ((nxt_pos < count_reg) && free_vec[nxt_pos[IW-1:0]])
                begin
                    cmd.op     = ffsa_pkg::OP_MERGE;
                    count_next = count_reg - CW'(1);
                end
                state_next = S_MPREV;
            end
            S_MPREV:
            begin
                pos_sel = prv_pos;
                if ((pos_reg != '0) && free_vec[prv_pos[IW-1:0]])
                begin
                    cmd.op     = ffsa_pkg::OP_MERGE;
                    count_next = count_reg - CW'(1);
                end
                res_next   = ffsa_pkg::ST_FREED;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (note_skip && (skcnt_reg < SCW'(MAX_SKIPPED)))
        begin
            skcnt_next = skcnt_reg + SCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CW'(1);
            skcnt_reg     <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= 1'b0;
            id_reg        <= '0;
            size_reg      <= '0;
            j_reg         <= '0;
            pos_reg       <= '0;
            skidx_reg     <= '0;
            res_reg       <= ffsa_pkg::ST_PLACED;
            status_reg    <= ffsa_pkg::ST_PLACED;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            skcnt_reg     <= skcnt_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            id_reg        <= id_next;
            size_reg      <= size_next;
            j_reg         <= j_next;
            pos_reg       <= pos_next;
            skidx_reg     <= skidx_next;
            res_reg       <= res_next;
            status_reg    <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= CW'(MAX_SEGMENTS)))
        else $error("segment count out of range");

    a_skip_range: assert property (@(posedge clk) disable iff (!rst_n)
        skcnt_reg <= SCW'(MAX_SKIPPED))
        else $error("skipped count out of range");

    a_token_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(toks))
        else $error("more than one scan token");

    a_token_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (toks != '0) |-> (state_reg == S_SCAN))
        else $error("scan token outside scan");

    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) && !(out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("finished transfer not presented");

endmodule

// ===== hdl/ffsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ffsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ffsa_cell.sv =====
// One segment table cell: holds a segment, shifts with its neighbors, carries the scan token.
module ffsa_cell #(
    parameter bit FIRST        = 1'b0,
    parameter int MEMORY_BYTES = ffsa_pkg::MEMORY_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ffsa_pkg::cell_cmd_t  cmd,
    input  logic                 at_pos,
    input  logic                 past_pos,
    input  logic                 left_at,
    input  ffsa_pkg::seg_t       left_seg,
    input  ffsa_pkg::seg_t       right_seg,
    input  logic                 tok_in,
    output ffsa_pkg::seg_t       seg,
    output logic                 tok,
    output ffsa_pkg::cell_stat_t stat
);

    localparam ffsa_pkg::seg_t RESET_SEG = FIRST ?
        '{owner: ffsa_pkg::FREE_OWNER, start: '0,
          len: ffsa_pkg::LEN_W'(MEMORY_BYTES)} : '0;

    ffsa_pkg::seg_t seg_reg, seg_next;
    logic           tok_reg;
    logic           match;

    always_comb
    begin
        seg_next = seg_reg;
        unique case (cmd.op)
            ffsa_pkg::OP_HOLD:
            begin
            end
            ffsa_pkg::OP_SETOWN:
            begin
                if (at_pos)
                begin
                    seg_next.owner = cmd.owner;
                end
            end
            ffsa_pkg::OP_SPLIT:
            begin
                if (at_pos)
                begin
                    seg_next.owner = cmd.owner;
                    seg_next.len   = cmd.size;
                end
                else if (left_at)
                begin
                    // free remainder behind the new block
                    seg_next.owner = ffsa_pkg::FREE_OWNER;
                    seg_next.start = left_seg.start + cmd.size[ffsa_pkg::START_W-1:0];
                    seg_next.len   = left_seg.len - cmd.size;
                end
                else if (past_pos)
                begin
                    seg_next = left_seg;
                end
            end
            ffsa_pkg::OP_MERGE:
            begin
                if (at_pos)
                begin
                    seg_next.len = seg_reg.len + right_seg.len;
                end
                else if (past_pos)
                begin
                    seg_next = right_seg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg <= RESET_SEG;
            tok_reg <= 1'b0;
        end
        else
        begin
            seg_reg <= seg_next;
            tok_reg <= tok_in;
        end
    end

    always_comb
    begin
        if (cmd.find_free)
        begin
            match = seg_reg.owner[ffsa_pkg::OWNER_W-1] && (seg_reg.len >= cmd.size);
        end
        else
        begin
            match = (seg_reg.owner == {1'b0, cmd.id});
        end
    end

    assign seg          = seg_reg;
    assign tok          = tok_reg;
    assign stat.is_free = seg_reg.owner[ffsa_pkg::OWNER_W-1];
    assign stat.hit     = tok_reg & match;
    assign stat.exact   = tok_reg & (seg_reg.len == cmd.size);

endmodule
